>>> design/obua_pkg.sv
// ---------------------------------------------------------------------------
// obua_pkg: shared types and constants
// Quantity codes, fixed-point helpers and sizes for the face advection block.
// ---------------------------------------------------------------------------
package obua_pkg;

   localparam int NUM_POINTS_DEF = 4;
   localparam int FACE_NODES_DEF = 4;
   localparam int ELEM_NODES_DEF = 8;
   localparam int DIMS_DEF       = 3;

   localparam logic [30:0] PTS_RESET = 31'd65536;
   localparam logic [30:0] PEN_RESET = 31'd262144;

   localparam logic [3:0] Q_DETJ  = 4'd0;
   localparam logic [3:0] Q_WGT   = 4'd1;
   localparam logic [3:0] Q_SHAPE = 4'd2;
   localparam logic [3:0] Q_GRAD  = 4'd3;
   localparam logic [3:0] Q_NORM  = 4'd4;
   localparam logic [3:0] Q_MAP   = 4'd5;
   localparam logic [3:0] Q_SCAL0 = 4'd6;
   localparam logic [3:0] Q_SCAL4 = 4'd10;
   localparam logic [3:0] Q_VEL   = 4'd11;
   localparam logic [3:0] Q_PGRAD = 4'd12;
   localparam logic [3:0] Q_DYNP  = 4'd13;
   localparam logic [3:0] Q_EPRES = 4'd14;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   localparam logic CSR_PTS = 1'b0;
   localparam logic CSR_PEN = 1'b1;

   // start strobe and operands of one shared multiply step
   typedef struct packed {
      logic        start;
      logic [31:0] a;
      logic [31:0] b;
   } mac_req_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
      if (x > 64'sh00007fffffffffff) return 48'sh7fffffffffff;
      if (x < -64'sh0000800000000000) return 48'sh800000000000;
      return x[47:0];
   endfunction

endpackage

>>> design/open_boundary_upwind_advection_assembly.sv
// ---------------------------------------------------------------------------
// open_boundary_upwind_advection_assembly: face advection term assembly
// Loads per-face stores, then assembles matrix and right-side increments.
// ---------------------------------------------------------------------------
// A load transaction (cmd 0) writes one stored value.
// A run transaction (cmd 1) walks every integration point through one shared
// registered multiplier: each product passes through operand fetch, issue
// and use. Afterwards FACE_NODES*(FACE_NODES+1) results are sent, matrix
// terms first (row outer), then right-side terms; the last one has tlast set.
// The request side is not ready from acceptance of a run until its last
// result is taken. Stores hold whatever was last loaded; no clearing pass.
module open_boundary_upwind_advection_assembly
   import obua_pkg::*;
#(
   parameter int NUM_POINTS = NUM_POINTS_DEF,
   parameter int FACE_NODES = FACE_NODES_DEF,
   parameter int ELEM_NODES = ELEM_NODES_DEF,
   parameter int DIMS       = DIMS_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: quantity[3:0], ip_index[5:4], node_index[8:6], dim_index[10:9],
   //        value[42:11], zero fill to 48 bits
   input  logic [47:0] req_tdata,
   // tuser: cmd
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: row[2:0], col[5:3], increment[37:6], zero fill to 40 bits
   output logic [39:0] rsp_tdata,
   // tuser: is_rhs
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [30:0] csr_wdata
);
   localparam int PW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
   localparam int FW = $clog2(FACE_NODES);
   localparam int EW = $clog2(ELEM_NODES);
   localparam int DW = $clog2(DIMS);
   localparam int NOUT = FACE_NODES * FACE_NODES + FACE_NODES;
   localparam int OW = $clog2(NOUT + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ISSUE = 3'd1;
   localparam logic [2:0] S_USE   = 3'd2;
   localparam logic [2:0] S_EMIT  = 3'd3;
   localparam logic [2:0] S_FETCH = 3'd4;

   // micro steps within one point
   localparam logic [4:0] P_IPF   = 5'd0;  // det*weight
   localparam logic [4:0] P_RRHO  = 5'd1;  // r*rho, per face node
   localparam logic [4:0] P_SL    = 5'd2;  // grad.normal, per face node, dim
   localparam logic [4:0] P_SRV   = 5'd3;  // rrho*vel
   localparam logic [4:0] P_SG    = 5'd4;  // r*pgrad
   localparam logic [4:0] P_SQ    = 5'd5;  // r*scalars 0..3 (dim = kind)
   localparam logic [4:0] P_SD    = 5'd6;  // grad*pressure, per elem node, dim
   localparam logic [4:0] P_PP    = 5'd7;  // pen*pts
   localparam logic [4:0] P_PSL   = 5'd8;  // *sl
   localparam logic [4:0] P_PDP   = 5'd9;  // *(sp-spbc)
   localparam logic [4:0] P_TDG   = 5'd10; // pts*dg, per dim
   localparam logic [4:0] P_TN    = 5'd11; // t*normal, per dim
   localparam logic [4:0] P_FQ    = 5'd12; // flux*sq or sqe
   localparam logic [4:0] P_ADV   = 5'd13; // *ipf
   localparam logic [4:0] P_FAC   = 5'd14; // flux*ipf
   localparam logic [4:0] P_RHS   = 5'd15; // w*adv, per row
   localparam logic [4:0] P_WW    = 5'd16; // w*w, per row, col
   localparam logic [4:0] P_LHS   = 5'd17; // *fac

   // stores
   logic signed [31:0] detj_ff  [NUM_POINTS];
   logic signed [31:0] wgt_ff   [NUM_POINTS];
   logic signed [31:0] shape_ff [NUM_POINTS][FACE_NODES];
   logic signed [31:0] grad_ff  [NUM_POINTS][ELEM_NODES][DIMS];
   logic signed [31:0] norm_ff  [NUM_POINTS][DIMS];
   logic [2:0]         map_ff   [FACE_NODES];
   logic signed [31:0] scal_ff  [5][FACE_NODES];
   logic signed [31:0] vec_ff   [2][FACE_NODES][DIMS];
   logic signed [31:0] dynp_ff  [NUM_POINTS];
   logic signed [31:0] epres_ff [ELEM_NODES];
   logic signed [47:0] lhs_ff   [FACE_NODES][FACE_NODES];
   logic signed [47:0] rhs_ff   [FACE_NODES];

   logic [30:0] pts_ff, pen_ff;

   // point intermediates
   logic signed [63:0] acc_ff [5]; // sl sq sqe sp spbc
   logic signed [63:0] srv_ff [DIMS];
   logic signed [63:0] sg_ff  [DIMS];
   logic signed [63:0] sd_ff  [DIMS];
   logic signed [63:0] mf_ff;
   logic signed [31:0] ipf_ff, rrho_ff, tmp_ff, flux_ff, adv_ff, fac_ff;
   logic signed [31:0] grad_rd_ff;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   logic [PW-1:0] ip_ff;
   logic [4:0]  i_ff, j_ff; // node and dim/col counters
   logic [OW-1:0] oc_ff;
   logic [FW-1:0] orow_ff, ocol_ff;

   mac_req_type        mreq;
   logic signed [31:0] prod;

   obua_mul u_mul (.clock(clock), .req(mreq), .prod(prod));

   // input fields
   logic [3:0]         f_q;
   logic [1:0]         f_ip;
   logic [2:0]         f_nd;
   logic [1:0]         f_dm;
   logic signed [31:0] f_val;
   assign f_q   = req_tdata[3:0];
   assign f_ip  = req_tdata[5:4];
   assign f_nd  = req_tdata[8:6];
   assign f_dm  = req_tdata[10:9];
   assign f_val = req_tdata[42:11];

   logic req_fire, rsp_fire;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   logic ipok, fok, eok, dok;
   assign ipok = 32'(f_ip) < NUM_POINTS;
   assign fok  = 32'(f_nd) < FACE_NODES;
   assign eok  = 32'(f_nd) < ELEM_NODES;
   assign dok  = 32'(f_dm) < DIMS;

   // --- loads and config ---
   always_ff @(posedge clock) begin
      if (req_fire && req_tuser == CMD_LOAD) begin
         case (f_q)
            Q_DETJ:  if (ipok) detj_ff[f_ip[PW-1:0]] <= f_val;
            Q_WGT:   if (ipok) wgt_ff[f_ip[PW-1:0]] <= f_val;
            Q_SHAPE: if (ipok && fok) shape_ff[f_ip[PW-1:0]][f_nd[FW-1:0]] <= f_val;
            Q_GRAD:  if (ipok && eok && dok)
                        grad_ff[f_ip[PW-1:0]][f_nd[EW-1:0]][f_dm[DW-1:0]] <= f_val;
            Q_NORM:  if (ipok && dok) norm_ff[f_ip[PW-1:0]][f_dm[DW-1:0]] <= f_val;
            Q_MAP:   if (fok) map_ff[f_nd[FW-1:0]] <= f_val[2:0];
            Q_VEL, Q_PGRAD: if (fok && dok)
                        vec_ff[1'(f_q - Q_VEL)][f_nd[FW-1:0]][f_dm[DW-1:0]] <= f_val;
            Q_DYNP:  if (ipok) dynp_ff[f_ip[PW-1:0]] <= f_val;
            Q_EPRES: if (eok) epres_ff[f_nd[EW-1:0]] <= f_val;
            default: begin
               if (f_q >= Q_SCAL0 && f_q <= Q_SCAL4 && fok)
                  scal_ff[3'(f_q - Q_SCAL0)][f_nd[FW-1:0]] <= f_val;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pts_ff <= PTS_RESET;
         pen_ff <= PEN_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_PTS) pts_ff <= csr_wdata;
         else pen_ff <= csr_wdata;
      end
   end

   // --- operand select ---
   logic [FW-1:0] fi, fj;
   logic [EW-1:0] ei, gnode;
   logic [DW-1:0] dj;
   logic [2:0]    mnode;
   logic signed [31:0] dg, tt, sl32, dp32;
   assign fi = i_ff[FW-1:0];
   assign fj = j_ff[FW-1:0];
   assign ei = i_ff[EW-1:0];
   assign dj = j_ff[DW-1:0];
   assign mnode = map_ff[fi];
   assign sl32 = sat32(acc_ff[0]);
   assign dp32 = sat32(64'(sat32(acc_ff[3])) - 64'(sat32(acc_ff[4])));
   assign dg = sat32(64'(sat32(sd_ff[dj])) - 64'(sat32(sg_ff[dj])));
   assign tt = sat32(64'(sat32(srv_ff[dj])) - 64'(tmp_ff));

   // gradient store read, registered during the fetch cycle
   assign gnode = (step_ff == P_SL) ? mnode[EW-1:0] : ei;

   always_ff @(posedge clock) begin
      grad_rd_ff <= grad_ff[ip_ff][gnode][dj];
   end

   logic leaving;
   assign leaving = flux_ff > 32'sd0;

   always_comb begin
      mreq.start = (state_ff == S_ISSUE);
      mreq.a = '0;
      mreq.b = '0;
      case (step_ff)
         P_IPF:  begin mreq.a = detj_ff[ip_ff]; mreq.b = wgt_ff[ip_ff]; end
         P_RRHO: begin mreq.a = shape_ff[ip_ff][fi]; mreq.b = scal_ff[4][fi]; end
         P_SL:   begin
            mreq.a = (32'(mnode) < ELEM_NODES) ? grad_rd_ff : '0;
            mreq.b = norm_ff[ip_ff][dj];
         end
         P_SRV:  begin mreq.a = rrho_ff; mreq.b = vec_ff[0][fi][dj]; end
         P_SG:   begin mreq.a = shape_ff[ip_ff][fi]; mreq.b = vec_ff[1][fi][dj]; end
         P_SQ:   begin mreq.a = shape_ff[ip_ff][fi]; mreq.b = scal_ff[j_ff[2:0]][fi]; end
         P_SD:   begin mreq.a = grad_rd_ff; mreq.b = epres_ff[ei]; end
         P_PP:   begin mreq.a = {1'b0, pen_ff}; mreq.b = {1'b0, pts_ff}; end
         P_PSL:  begin mreq.a = tmp_ff; mreq.b = sl32; end
         P_PDP:  begin mreq.a = tmp_ff; mreq.b = dp32; end
         P_TDG:  begin mreq.a = {1'b0, pts_ff}; mreq.b = dg; end
         P_TN:   begin mreq.a = tt; mreq.b = norm_ff[ip_ff][dj]; end
         P_FQ:   begin
            mreq.a = flux_ff;
            mreq.b = leaving ? sat32(acc_ff[1]) : sat32(acc_ff[2]);
         end
         P_ADV:  begin mreq.a = tmp_ff; mreq.b = ipf_ff; end
         P_FAC:  begin mreq.a = flux_ff; mreq.b = ipf_ff; end
         P_RHS:  begin mreq.a = shape_ff[ip_ff][fi]; mreq.b = adv_ff; end
         P_WW:   begin mreq.a = shape_ff[ip_ff][fi]; mreq.b = shape_ff[ip_ff][fj]; end
         P_LHS:  begin mreq.a = tmp_ff; mreq.b = fac_ff; end
         default: ;
      endcase
   end

   // --- sequencer ---
   logic last_i_face, last_i_elem, last_j_dim, last_j_face, last_ip;
   assign last_i_face = (32'(i_ff) == FACE_NODES - 1);
   assign last_i_elem = (32'(i_ff) == ELEM_NODES - 1);
   assign last_j_dim  = (32'(j_ff) == DIMS - 1);
   assign last_j_face = (32'(j_ff) == FACE_NODES - 1);
   assign last_ip     = (32'(ip_ff) == NUM_POINTS - 1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_fire && req_tuser == CMD_RUN) state_in = S_FETCH;
         S_FETCH: state_in = S_ISSUE;
         S_ISSUE: state_in = S_USE;
         S_USE:   state_in = (step_ff == P_LHS && last_i_face && last_j_face && last_ip)
                             ? S_EMIT : S_FETCH;
         S_EMIT:  if (rsp_fire && 32'(oc_ff) == NOUT - 1) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end
   assign step_in = step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // counters and datapath update
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_fire && req_tuser == CMD_RUN) begin
         step_ff <= P_IPF;
         ip_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
         oc_ff <= '0;
         orow_ff <= '0;
         ocol_ff <= '0;
         for (int r = 0; r < FACE_NODES; r++) begin
            rhs_ff[r] <= '0;
            for (int c = 0; c < FACE_NODES; c++) lhs_ff[r][c] <= '0;
         end
         for (int k = 0; k < 5; k++) acc_ff[k] <= '0;
         for (int d = 0; d < DIMS; d++) begin
            srv_ff[d] <= '0; sg_ff[d] <= '0; sd_ff[d] <= '0;
         end
      end else if (state_ff == S_USE) begin
         case (step_ff)
            P_IPF: begin
               ipf_ff <= prod;
               acc_ff[4] <= -64'(dynp_ff[ip_ff]);
               step_ff <= P_RRHO;
            end
            P_RRHO: begin rrho_ff <= prod; step_ff <= P_SL; j_ff <= '0; end
            P_SL: begin
               acc_ff[0] <= acc_ff[0] + 64'(prod);
               if (last_j_dim) begin j_ff <= '0; step_ff <= P_SRV; end
               else j_ff <= j_ff + 5'd1;
            end
            P_SRV: begin
               srv_ff[dj] <= srv_ff[dj] + 64'(prod);
               if (last_j_dim) begin j_ff <= '0; step_ff <= P_SG; end
               else j_ff <= j_ff + 5'd1;
            end
            P_SG: begin
               sg_ff[dj] <= sg_ff[dj] + 64'(prod);
               if (last_j_dim) begin j_ff <= '0; step_ff <= P_SQ; end
               else j_ff <= j_ff + 5'd1;
            end
            P_SQ: begin
               acc_ff[j_ff[2:0] + 3'd1] <= acc_ff[j_ff[2:0] + 3'd1] + 64'(prod);
               if (j_ff == 5'd3) begin
                  j_ff <= '0;
                  if (last_i_face) begin i_ff <= '0; step_ff <= P_SD; end
                  else begin i_ff <= i_ff + 5'd1; step_ff <= P_RRHO; end
               end else j_ff <= j_ff + 5'd1;
            end
            P_SD: begin
               sd_ff[dj] <= sd_ff[dj] + 64'(prod);
               if (last_j_dim) begin
                  j_ff <= '0;
                  if (last_i_elem) begin i_ff <= '0; step_ff <= P_PP; end
                  else i_ff <= i_ff + 5'd1;
               end else j_ff <= j_ff + 5'd1;
            end
            P_PP:  begin tmp_ff <= prod; step_ff <= P_PSL; end
            P_PSL: begin tmp_ff <= prod; step_ff <= P_PDP; end
            P_PDP: begin mf_ff <= 64'(prod); j_ff <= '0; step_ff <= P_TDG; end
            P_TDG: begin tmp_ff <= prod; step_ff <= P_TN; end
            P_TN: begin
               if (last_j_dim) begin
                  flux_ff <= sat32(mf_ff + 64'(prod));
                  j_ff <= '0;
                  step_ff <= P_FQ;
               end else begin
                  mf_ff <= mf_ff + 64'(prod);
                  j_ff <= j_ff + 5'd1;
                  step_ff <= P_TDG;
               end
            end
            P_FQ:  begin tmp_ff <= prod; step_ff <= P_ADV; end
            P_ADV: begin adv_ff <= prod; step_ff <= P_FAC; end
            P_FAC: begin
               fac_ff <= leaving ? prod : 32'sd0;
               i_ff <= '0;
               step_ff <= P_RHS;
            end
            P_RHS: begin
               rhs_ff[fi] <= sat48(64'(rhs_ff[fi]) - 64'(prod));
               if (last_i_face) begin i_ff <= '0; j_ff <= '0; step_ff <= P_WW; end
               else i_ff <= i_ff + 5'd1;
            end
            P_WW:  begin tmp_ff <= prod; step_ff <= P_LHS; end
            P_LHS: begin
               lhs_ff[fi][fj] <= sat48(64'(lhs_ff[fi][fj]) + 64'(prod));
               step_ff <= P_WW;
               if (last_j_face) begin
                  j_ff <= '0;
                  if (last_i_face) begin
                     i_ff <= '0;
                     step_ff <= P_IPF;
                     if (!last_ip) ip_ff <= ip_ff + PW'(1);
                     for (int k = 0; k < 5; k++) acc_ff[k] <= '0;
                     for (int d = 0; d < DIMS; d++) begin
                        srv_ff[d] <= '0; sg_ff[d] <= '0; sd_ff[d] <= '0;
                     end
                  end else i_ff <= i_ff + 5'd1;
               end else j_ff <= j_ff + 5'd1;
            end
            default: step_ff <= step_in;
         endcase
      end else if (state_ff == S_EMIT && rsp_fire) begin
         oc_ff <= oc_ff + OW'(1);
         if (32'(ocol_ff) == FACE_NODES - 1 || 32'(oc_ff) >= FACE_NODES * FACE_NODES) begin
            ocol_ff <= '0;
            orow_ff <= (32'(orow_ff) == FACE_NODES - 1) ? '0 : orow_ff + FW'(1);
         end else ocol_ff <= ocol_ff + FW'(1);
      end
   end

   // --- result channel, driven straight from the accumulators ---
   logic is_rhs;
   logic signed [31:0] incr;
   assign is_rhs = 32'(oc_ff) >= FACE_NODES * FACE_NODES;
   assign incr = is_rhs ? sat32(64'(rhs_ff[orow_ff])) : sat32(64'(lhs_ff[orow_ff][ocol_ff]));
   assign rsp_tvalid = (state_ff == S_EMIT);
   assign rsp_tuser  = is_rhs;
   assign rsp_tlast  = (32'(oc_ff) == NOUT - 1);
   assign rsp_tdata  = {2'b00, incr, (is_rhs ? 3'd0 : map_ff[ocol_ff]), map_ff[orow_ff]};

   // --- checks ---
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast) |=> (state_ff == S_IDLE)) else $error("run did not end");
   a_rhs_col0: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[5:3] == 3'd0)) else $error("rhs column");
endmodule

>>> design/obua_mul.sv
// ---------------------------------------------------------------------------
// obua_mul: shared q16.16 multiplier
// Registered product with round-half-up and 32-bit saturation.
// ---------------------------------------------------------------------------
module obua_mul
   import obua_pkg::*;
(
   input  logic               clock,
   input  mac_req_type        req,
   output logic signed [31:0] prod
);
   logic signed [63:0] full_ff, full_in;
   logic signed [63:0] rnd;

   always_comb begin
      full_in = $signed(req.a) * $signed(req.b);
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         full_ff <= full_in;
      end
   end

   // arithmetic shift right floors toward minus infinity
   assign rnd  = (full_ff + 64'sd32768) >>> 16;
   assign prod = sat32(rnd);
endmodule
